// ----- src/sem_pkg.sv -----
// Shared types and constants for the Sobel edge magnitude unit.
// No dependencies; used by sem_lane and the top level.
`default_nettype none
package sem_pkg;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WID_W      = 11;
    localparam int HGT_W      = 13;
    localparam int ROW_W      = $clog2(MAX_HEIGHT) + 1;
    localparam int CFG_W      = 13;
    localparam int PIX_W      = 24;
    localparam int LANES      = 3;
    localparam int ROOT_STEPS = 8;
    localparam int SUM_W      = 22;

    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    localparam logic MODE_PIXEL = 1'b0;

    typedef logic [8:0][7:0] t_chan_win;

    typedef struct packed {
        logic       load_grad;
        logic       load_sq;
        logic       step;
        logic [2:0] bit_idx;
    } t_lane_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_GRAD,
        ST_SQ,
        ST_ROOT,
        ST_DONE
    } t_state;
endpackage
`default_nettype wire

// ----- src/sem_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
`default_nettype none
module sem_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- src/sem_lane.sv -----
// One colour lane: Sobel gradients, squared sum and an 8-step rounded root.
// Depends on sem_pkg.
`default_nettype none
module sem_lane (
    input  wire logic                 i_clk,
    input  wire sem_pkg::t_lane_ctl   i_ctl,
    input  wire sem_pkg::t_chan_win   i_win,
    input  wire logic [8:0]           i_keep,
    output logic [7:0]                o_edge
);
    localparam int SUM_W = sem_pkg::SUM_W;

    logic signed [11:0]               r_gx, r_gy;
    logic [sem_pkg::SUM_W-1:0]        r_s;
    logic [7:0]                       r_t;
    logic signed [11:0]               v [9];
    logic signed [11:0]               n_gx, n_gy;
    logic [23:0]                      sq_x, sq_y;
    logic [7:0]                       cand;
    logic [16:0]                      prod;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            v[k] = i_keep[k] ? $signed({4'b0, i_win[k]}) : 12'sd0;
        end
        n_gx = (v[2] - v[0]) + 12'sd2 * (v[5] - v[3]) + (v[8] - v[6]);
        n_gy = (v[6] - v[0]) + 12'sd2 * (v[7] - v[1]) + (v[8] - v[2]);
        sq_x = 24'(24'(r_gx) * 24'(r_gx));
        sq_y = 24'(24'(r_gy) * 24'(r_gy));
        cand = r_t | 8'(1 << i_ctl.bit_idx);
        prod = 17'({9'b0, cand} * ({1'b0, cand} + 9'd1));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_grad) begin
            r_gx <= n_gx;
            r_gy <= n_gy;
        end
        if (i_ctl.load_sq) begin
            r_s <= SUM_W'({1'b0, sq_x} + {1'b0, sq_y});
            r_t <= 8'd0;
        end
        // keep the candidate bit while cand*(cand+1) stays below the sum
        if (i_ctl.step && ({5'b0, prod} < r_s)) begin
            r_t <= cand;
        end
    end

    always_comb begin
        if (r_s > SUM_W'(65280)) begin
            o_edge = 8'd255;
        end else if (r_s == '0) begin
            o_edge = 8'd0;
        end else begin
            o_edge = r_t + 8'd1;
        end
    end
endmodule
`default_nettype wire

// ----- src/sobel_edge_magnitude_rgb_unit.sv -----
// Top level of the streaming RGB Sobel edge magnitude unit.
// Depends on sem_pkg, sem_ram and sem_lane.
`default_nettype none
// Takes RGB pixels in raster order (mode 0) and returns, per colour, the
// rounded Sobel gradient magnitude saturated at 255, with pixels outside the
// frame taken as zero. Results trail the input by frame_width + 1 beats;
// after a frame's last pixel send frame_width + 1 flush beats (mode 1) to
// drain it, and frame_end marks the result for the last pixel. After an item
// is accepted it passes a line store read, gradient, square-sum, eight root
// search steps and a hand-off into the output register; the next beat is
// taken only once the unit is back in idle. A beat that yields no result
// returns to idle after the line store read, and a flush beat ignored
// mid-frame leaves the unit idle. The output register lets the next beat
// be accepted while a result waits. A configuration write restarts the
// frame; write only while the unit is idle. Line stores need no clearing
// after reset: every entry not yet written in a frame lands on a masked
// window cell.
module sobel_edge_magnitude_rgb_unit (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic                     i_cfg_index,
    input  wire logic [sem_pkg::CFG_W-1:0] i_cfg_data,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic                     i_mode,
    input  wire logic [7:0]               i_blue_in,
    input  wire logic [7:0]               i_green_in,
    input  wire logic [7:0]               i_red_in,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic [7:0]                    o_blue_edge,
    output logic [7:0]                    o_green_edge,
    output logic [7:0]                    o_red_edge,
    output logic                          o_frame_end
);
    localparam int COL_W = sem_pkg::COL_W;
    localparam int WID_W = sem_pkg::WID_W;
    localparam int HGT_W = sem_pkg::HGT_W;
    localparam int ROW_W = sem_pkg::ROW_W;
    localparam int PIX_W = sem_pkg::PIX_W;

    sem_pkg::t_state         r_state, n_state;
    logic [WID_W-1:0]        r_fw;
    logic [HGT_W-1:0]        r_fh;
    logic [COL_W-1:0]        r_col, r_cur_col;
    logic [ROW_W-1:0]        r_row, r_cur_row;
    logic [PIX_W-1:0]        r_pix;
    logic [PIX_W-1:0]        r_win [9];
    logic [8:0]              r_keep;
    logic                    r_have, r_fe;
    logic [2:0]              r_bit;
    logic                    r_out_valid;
    logic [7:0]              r_out_b, r_out_g, r_out_r;
    logic                    r_out_fe;

    logic [WID_W-1:0]        w_eff;
    logic [HGT_W-1:0]        h_eff;
    logic                    accept, in_frame, ignore;
    logic [WID_W-1:0]        col_inc;
    logic [PIX_W-1:0]        up_q, mid_q;
    logic                    ram_we;
    logic                    have;
    logic [ROW_W-1:0]        orow;
    logic [COL_W-1:0]        ocol;
    logic [2:0]              row_ok, col_ok;
    logic                    fe;
    logic                    out_free;
    sem_pkg::t_lane_ctl      lane_ctl;
    sem_pkg::t_chan_win      lane_win [sem_pkg::LANES];
    logic [7:0]              lane_edge [sem_pkg::LANES];

    // clamp the frame size registers to the usable range
    always_comb begin
        if (r_fw == '0) begin
            w_eff = WID_W'(1);
        end else if (r_fw > WID_W'(sem_pkg::MAX_WIDTH)) begin
            w_eff = WID_W'(sem_pkg::MAX_WIDTH);
        end else begin
            w_eff = r_fw;
        end
        if (r_fh == '0) begin
            h_eff = HGT_W'(1);
        end else if (r_fh > HGT_W'(sem_pkg::MAX_HEIGHT)) begin
            h_eff = HGT_W'(sem_pkg::MAX_HEIGHT);
        end else begin
            h_eff = r_fh;
        end
    end

    assign accept   = i_in_valid && !o_in_stall;
    assign in_frame = r_row < ROW_W'(h_eff);
    // a flush beat before the frame is complete is dropped
    assign ignore   = (i_mode != sem_pkg::MODE_PIXEL) && in_frame;
    assign col_inc  = WID_W'(r_col) + WID_W'(1);
    assign out_free = !r_out_valid || !i_out_stall;

    // upper line store shifts the middle row up; middle takes the new pixel
    sem_ram #(.WIDTH(PIX_W), .DEPTH(sem_pkg::MAX_WIDTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cur_col),
        .i_wdata (mid_q),
        .i_raddr (r_col),
        .o_rdata (up_q)
    );

    sem_ram #(.WIDTH(PIX_W), .DEPTH(sem_pkg::MAX_WIDTH)) u_middle (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cur_col),
        .i_wdata (r_pix),
        .i_raddr (r_col),
        .o_rdata (mid_q)
    );

    // position of the window center relative to the beat just taken
    always_comb begin
        if (r_cur_col != '0) begin
            have = r_cur_row >= ROW_W'(1);
            orow = r_cur_row - ROW_W'(1);
            ocol = r_cur_col - COL_W'(1);
        end else begin
            have = r_cur_row >= ROW_W'(2);
            orow = r_cur_row - ROW_W'(2);
            ocol = COL_W'(w_eff - WID_W'(1));
        end
        row_ok[0] = orow != '0;
        row_ok[1] = 1'b1;
        row_ok[2] = orow < ROW_W'(h_eff - HGT_W'(1));
        col_ok[0] = ocol != '0;
        col_ok[1] = 1'b1;
        col_ok[2] = WID_W'(ocol) < (w_eff - WID_W'(1));
        fe = !row_ok[2] && !col_ok[2];
    end

    // sequencer: next state and per-state strobes
    always_comb begin
        n_state  = r_state;
        o_in_stall = r_state != sem_pkg::ST_IDLE;
        ram_we   = 1'b0;
        lane_ctl = '{load_grad: 1'b0, load_sq: 1'b0, step: 1'b0, bit_idx: r_bit};
        case (r_state)
            sem_pkg::ST_IDLE: begin
                if (accept && !ignore) begin
                    n_state = sem_pkg::ST_READ;
                end
            end
            sem_pkg::ST_READ: begin
                ram_we  = 1'b1;
                n_state = have ? sem_pkg::ST_GRAD : sem_pkg::ST_IDLE;
            end
            sem_pkg::ST_GRAD: begin
                lane_ctl.load_grad = 1'b1;
                n_state = sem_pkg::ST_SQ;
            end
            sem_pkg::ST_SQ: begin
                lane_ctl.load_sq = 1'b1;
                n_state = sem_pkg::ST_ROOT;
            end
            sem_pkg::ST_ROOT: begin
                lane_ctl.step = 1'b1;
                if (r_bit == '0) begin
                    n_state = sem_pkg::ST_DONE;
                end
            end
            sem_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = sem_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sem_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sem_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // frame size registers and raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw  <= WID_W'(640);
            r_fh  <= HGT_W'(480);
            r_col <= '0;
            r_row <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == sem_pkg::CFG_FRAME_WIDTH) begin
                r_fw <= i_cfg_data[WID_W-1:0];
            end else begin
                r_fh <= i_cfg_data[HGT_W-1:0];
            end
            r_col <= '0;
            r_row <= '0;
        end else if (r_state == sem_pkg::ST_IDLE && accept && !ignore) begin
            if (col_inc >= w_eff) begin
                r_col <= '0;
                r_row <= r_row + ROW_W'(1);
            end else begin
                r_col <= col_inc[COL_W-1:0];
            end
        end else if (r_state == sem_pkg::ST_READ && have && fe) begin
            // last pixel of the frame: restart the raster
            r_col <= '0;
            r_row <= '0;
        end
    end

    // beat capture, window shift and cell masks
    always_ff @(posedge i_clk) begin
        if (r_state == sem_pkg::ST_IDLE && accept) begin
            r_cur_col <= r_col;
            r_cur_row <= r_row;
            r_pix     <= in_frame ? {i_red_in, i_green_in, i_blue_in} : '0;
        end
        if (r_state == sem_pkg::ST_READ) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i*3]   <= r_win[i*3+1];
                r_win[i*3+1] <= r_win[i*3+2];
            end
            r_win[2] <= up_q;
            r_win[5] <= mid_q;
            r_win[8] <= r_pix;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_keep[i*3+j] <= row_ok[i] && col_ok[j];
                end
            end
            r_have <= have;
            r_fe   <= fe;
        end
        if (r_state == sem_pkg::ST_SQ) begin
            r_bit <= 3'(sem_pkg::ROOT_STEPS - 1);
        end else if (r_state == sem_pkg::ST_ROOT) begin
            r_bit <= r_bit - 3'd1;
        end
    end

    // split the window into per-colour slices: blue, green, red
    always_comb begin
        for (int g = 0; g < sem_pkg::LANES; g++) begin
            for (int k = 0; k < 9; k++) begin
                lane_win[g][k] = r_win[k][g*8 +: 8];
            end
        end
    end

    // colour lanes: blue, green, red
    for (genvar g = 0; g < sem_pkg::LANES; g++) begin : g_lane
        sem_lane u_lane (
            .i_clk  (i_clk),
            .i_ctl  (lane_ctl),
            .i_win  (lane_win[g]),
            .i_keep (r_keep),
            .o_edge (lane_edge[g])
        );
    end

    // merge the lanes into the output register; hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == sem_pkg::ST_DONE && out_free && r_have) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == sem_pkg::ST_DONE && out_free) begin
            r_out_b  <= lane_edge[0];
            r_out_g  <= lane_edge[1];
            r_out_r  <= lane_edge[2];
            r_out_fe <= r_fe;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_blue_edge  = r_out_b;
    assign o_green_edge = r_out_g;
    assign o_red_edge   = r_out_r;
    assign o_frame_end  = r_out_fe;
endmodule
`default_nettype wire

// ----- tb/sobel_edge_magnitude_rgb_checker.sv -----
// Checker for the RGB Sobel edge magnitude unit: tracks the frame geometry,
// predicts every result beat and compares it with what the unit returns.
// Depends on sem_pkg for sizes, register indexes and the mode code.
module sobel_edge_magnitude_rgb_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [sem_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic                      i_mode,
    input  logic [7:0]                i_blue_in,
    input  logic [7:0]                i_green_in,
    input  logic [7:0]                i_red_in,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic [7:0]                i_blue_edge,
    input  logic [7:0]                i_green_edge,
    input  logic [7:0]                i_red_edge,
    input  logic                      i_frame_end,
    output int                        o_fail_count,
    output int                        o_owed,
    output int                        o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       last;
    } t_grad;

    t_grad           grad_due[$];
    logic [23:0]     upper_row [sem_pkg::MAX_WIDTH];
    logic [23:0]     middle_row[sem_pkg::MAX_WIDTH];
    logic [23:0]     win[9];
    int unsigned     col_pos;
    int unsigned     row_pos;
    logic [sem_pkg::WID_W-1:0] width_reg;
    logic [sem_pkg::HGT_W-1:0] height_reg;

    function automatic int unsigned active_width();
        if (width_reg == 0) return 1;
        if (width_reg > sem_pkg::MAX_WIDTH) return sem_pkg::MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned active_height();
        if (height_reg == 0) return 1;
        if (height_reg > sem_pkg::MAX_HEIGHT) return sem_pkg::MAX_HEIGHT;
        return height_reg;
    endfunction

    // Rounded square root by the half-integer bound, saturated at 255.
    function automatic logic [7:0] lane_grad(logic [8:0] keep, int sh);
        int v[9];
        int gx, gy, s;
        for (int k = 0; k < 9; k++)
            v[k] = keep[k] ? int'((win[k] >> sh) & 24'hff) : 0;
        gx = (v[2] - v[0]) + 2 * (v[5] - v[3]) + (v[8] - v[6]);
        gy = (v[6] - v[0]) + 2 * (v[7] - v[1]) + (v[8] - v[2]);
        s = gx * gx + gy * gy;
        if (s > 65280) return 8'd255;
        for (int r = 0; r < 255; r++)
            if (s <= r * r + r) return r[7:0];
        return 8'd255;
    endfunction

    task automatic take_beat(input logic mode, input logic [23:0] px_in);
        int unsigned w, h, c, r, orow, ocol;
        logic [23:0] px, up, mid;
        logic [8:0]  keep;
        bit          have;
        t_grad       res;
        w = active_width();
        h = active_height();
        c = col_pos;
        r = row_pos;
        // Flush mid-frame: ignored entirely.
        if (mode != sem_pkg::MODE_PIXEL && r < h) return;
        // Pixel during drain behaves as a flush: data dropped.
        px = (mode == sem_pkg::MODE_PIXEL && r < h) ? px_in : 24'd0;
        if (c >= sem_pkg::MAX_WIDTH) c = 0;
        up = upper_row[c];
        mid = middle_row[c];
        upper_row[c] = mid;
        middle_row[c] = px;
        for (int i = 0; i < 3; i++) begin
            win[i*3] = win[i*3+1];
            win[i*3+1] = win[i*3+2];
        end
        win[2] = up;
        win[5] = mid;
        win[8] = px;
        if (c > 0) begin
            have = r >= 1;
            orow = r - 1;
            ocol = c - 1;
        end else begin
            have = r >= 2;
            orow = r - 2;
            ocol = w - 1;
        end
        col_pos = c + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
        end
        if (!have) return;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                keep[i*3+j] = !((i == 0 && orow == 0) || (i == 2 && orow >= h - 1) ||
                                (j == 0 && ocol == 0) || (j == 2 && ocol >= w - 1));
        res.blue  = lane_grad(keep, 0);
        res.green = lane_grad(keep, 8);
        res.red   = lane_grad(keep, 16);
        res.last  = (orow >= h - 1) && (ocol >= w - 1);
        if (res.last) begin
            col_pos = 0;
            row_pos = 0;
        end
        grad_due.push_back(res);
    endtask

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_grad want;
        if (!i_rst_n) begin
            o_fail_count = 0;
            o_checked = 0;
            width_reg = 640;
            height_reg = 480;
            col_pos = 0;
            row_pos = 0;
            for (int k = 0; k < sem_pkg::MAX_WIDTH; k++) begin
                upper_row[k] = '0;
                middle_row[k] = '0;
            end
            for (int k = 0; k < 9; k++) win[k] = '0;
            grad_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_checked++;
                if (grad_due.size() == 0) begin
                    $display("unexpected result beat at %0t", $realtime);
                    o_fail_count++;
                end else begin
                    want = grad_due.pop_front();
                    if (i_blue_edge !== want.blue)
                        flag_mismatch("blue_edge", i_blue_edge, want.blue);
                    if (i_green_edge !== want.green)
                        flag_mismatch("green_edge", i_green_edge, want.green);
                    if (i_red_edge !== want.red)
                        flag_mismatch("red_edge", i_red_edge, want.red);
                    if (i_frame_end !== want.last)
                        flag_mismatch("frame_end", i_frame_end, want.last);
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == sem_pkg::CFG_FRAME_WIDTH)
                    width_reg = i_cfg_data[sem_pkg::WID_W-1:0];
                else
                    height_reg = i_cfg_data[sem_pkg::HGT_W-1:0];
                col_pos = 0;
                row_pos = 0;
            end
            if (i_in_valid && !i_in_stall)
                take_beat(i_mode, {i_red_in, i_green_in, i_blue_in});
        end
        o_owed = grad_due.size();
    end
endmodule

// ----- tb/sobel_edge_magnitude_rgb_unit_tb.sv -----
// Testbench top for the RGB Sobel edge magnitude unit: drives frames,
// flush beats and size changes, and gives the verdict.
// Depends on sem_pkg, the unit and sobel_edge_magnitude_rgb_checker.
module sobel_edge_magnitude_rgb_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic MODE_FLUSH   = ~sem_pkg::MODE_PIXEL;
    localparam int   STALL_LIMIT  = 5000;  // cycles with no beat before giving up
    localparam int   LONG_HOLD    = 400;
    localparam int   RANDOM_PIX   = 300;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic             i_cfg_index;
    logic [sem_pkg::CFG_W-1:0] i_cfg_data;
    logic             i_in_valid;
    logic             o_in_stall;
    logic             i_mode;
    logic [7:0]       i_blue_in, i_green_in, i_red_in;
    logic             o_out_valid;
    logic             i_out_stall;
    logic [7:0]       o_blue_edge, o_green_edge, o_red_edge;
    logic             o_frame_end;

    int fail_count, owed, checked;
    int frames_sent, pixels_sent;
    bit calm;            // no idling on either side in the closing stretch
    bit long_hold_go;
    bit long_hold_done;

    sobel_edge_magnitude_rgb_unit i_dut (.*);

    sobel_edge_magnitude_rgb_checker i_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_stall(o_in_stall), .i_mode,
        .i_blue_in, .i_green_in, .i_red_in,
        .i_out_valid(o_out_valid), .i_out_stall,
        .i_blue_edge(o_blue_edge), .i_green_edge(o_green_edge),
        .i_red_edge(o_red_edge), .i_frame_end(o_frame_end),
        .o_fail_count(fail_count), .o_owed(owed), .o_checked(checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Offer one beat; hold it until accepted. Entered and left at a falling edge.
    task automatic put_beat(input logic mode, input logic [7:0] b, g, r);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_mode = mode;
        i_blue_in = b;
        i_green_in = g;
        i_red_in = r;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // Change frame size only once the unit has drained.
    task automatic set_size(input int wr, input int hr);
        i_in_valid = 1'b0;
        wait (owed == 0);
        repeat (20) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = sem_pkg::CFG_FRAME_WIDTH;
        i_cfg_data = wr[sem_pkg::CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_index = sem_pkg::CFG_FRAME_HEIGHT;
        i_cfg_data = hr[sem_pkg::CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One frame of w x h pixels (effective sizes), sprinkled with early flush
    // beats when noisy, then w + 1 drain beats, when noisy some of them stray pixels.
    task automatic run_frame(input int w, input int h, input bit noisy);
        for (int i = 0; i < w * h; i++) begin
            if (noisy && $urandom_range(0, 19) == 0)
                put_beat(MODE_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
            put_beat(sem_pkg::MODE_PIXEL, pick_level(), pick_level(), pick_level());
            pixels_sent++;
        end
        for (int j = 0; j <= w; j++) begin
            if (noisy && $urandom_range(0, 9) == 0)
                put_beat(sem_pkg::MODE_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
            else
                put_beat(MODE_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
        end
        frames_sent++;
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin
        i_out_stall = 1'b0;
        long_hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_go && !long_hold_done) begin
                i_out_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                i_out_stall = 1'b0;
                long_hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                i_out_stall = 1'b1;
                repeat ($urandom_range(1, 9)) @(negedge i_clk);
                i_out_stall = 1'b0;
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves a beat.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no beat for %0d cycles", STALL_LIMIT);
                $display("FAIL sobel_edge_magnitude_rgb_unit");
                $finish;
            end
        end
    end

    initial begin
        int w, h, start_pix;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = sem_pkg::CFG_FRAME_WIDTH;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_mode = sem_pkg::MODE_PIXEL;
        i_blue_in = '0;
        i_green_in = '0;
        i_red_in = '0;
        calm = 1'b0;
        long_hold_go = 1'b0;
        frames_sent = 0;
        pixels_sent = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: 3x3 checkerboard of extremes saturates every lane in some windows;
        // an early flush sits mid-frame and a stray pixel lands in the drain.
        set_size(3, 3);
        for (int i = 0; i < 9; i++) begin
            if (i == 4) put_beat(MODE_FLUSH, 8'd255, 8'd255, 8'd255);
            put_beat(sem_pkg::MODE_PIXEL, (i % 2) ? 8'd255 : 8'd0,
                     (i % 2) ? 8'd0 : 8'd255, (i < 3) ? 8'd255 : 8'd0);
        end
        put_beat(sem_pkg::MODE_PIXEL, 8'd255, 8'd255, 8'd255);
        for (int j = 0; j < 3; j++) put_beat(MODE_FLUSH, 8'd0, 8'd0, 8'd0);
        frames_sent++;

        // Zero sizes act as a single pixel frame.
        set_size(0, 0);
        run_frame(1, 1, 1'b0);

        // Oversized registers clamp to the widest and tallest frame; a short
        // partial frame stays in its first row and is abandoned by the next write.
        set_size(2047, 8191);
        run_frame(4, 2, 1'b0);
        set_size(sem_pkg::MAX_WIDTH, 2);
        run_frame(4, 1, 1'b0);   // partial frame, abandoned by the next write

        // Hold off the receiver long enough to back the unit up into its input.
        set_size(64, 4);
        long_hold_go = 1'b1;
        run_frame(64, 4, 1'b0);

        // Random frames, mostly small; quiet handshakes near the end.
        start_pix = pixels_sent;
        while (pixels_sent - start_pix < RANDOM_PIX) begin
            if (pixels_sent - start_pix > RANDOM_PIX * 3 / 4) calm = 1'b1;
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            set_size(w, h);
            run_frame(w, h, 1'b1);
        end
        i_in_valid = 1'b0;

        wait (owed == 0);
        repeat (40) @(negedge i_clk);
        $display("covered %0d frames, %0d pixels, %0d result beats checked",
                 frames_sent, pixels_sent, checked);
        $display("sizes from one pixel to the clamped maxima, flush noise and a long stall");
        if (fail_count == 0)
            $display("PASS sobel_edge_magnitude_rgb_unit");
        else
            $display("FAIL sobel_edge_magnitude_rgb_unit");
        $finish;
    end
endmodule

// ----- filelist.f -----
src/sem_pkg.sv
src/sem_ram.sv
src/sem_lane.sv
src/sobel_edge_magnitude_rgb_unit.sv
tb/sobel_edge_magnitude_rgb_checker.sv
tb/sobel_edge_magnitude_rgb_unit_tb.sv
